FILE: rtl/glpf_pkg.sv
// shared constants and types of the grid local peak finder
`default_nettype none

package glpf_pkg;

  localparam int HeightW  = 32;
  localparam int MaxCols  = 64;
  localparam int ColW     = $clog2(MaxCols);
  localparam int MaxRows  = 1024;
  localparam int RowW     = $clog2(MaxRows);
  localparam int CfgRowsW = 11;
  localparam int CfgColsW = 7;
  localparam int CfgDataW = 11;
  localparam int CfgIdxW  = 1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgGridRows = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgGridCols = CfgIdxW'(1);

  // reset geometry: 20 by 20
  localparam logic [RowW-1:0] ResetLastRow = RowW'(19);
  localparam logic [ColW-1:0] ResetLastCol = ColW'(19);

  // hit bit positions, also the raster order of the results of one word
  localparam int HitAbove = 0;
  localparam int HitLeft  = 1;
  localparam int HitSelf  = 2;
  localparam int HitW     = 3;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  typedef struct packed {
    logic [HitW-1:0] hits;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            last_cell;
  } glpf_evt_t;

endpackage

`default_nettype wire

FILE: rtl/glpf_if.sv
// stream channels of the grid local peak finder
`default_nettype none

interface glpf_in_if import glpf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [HeightW-1:0] height;

  modport source (output valid, output height, input ready);
  modport sink (input valid, input height, output ready);
endinterface

interface glpf_out_if import glpf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [RowW-1:0] peak_row;
  logic [ColW-1:0] peak_col;
  logic            last_of_run;
  logic            grid_done;

  modport source (output valid, output peak_row, output peak_col, output last_of_run,
                  output grid_done, input ready);
  modport sink (input valid, input peak_row, input peak_col, input last_of_run,
                input grid_done, output ready);
endinterface

`default_nettype wire

FILE: rtl/grid_local_peak_finder_top.sv
// top level of the grid local peak finder
//
//   port        dir   word                                    size
//   in_i        sink  height                                  32
//   out_o       src   peak_row, peak_col, last_of_run,        10+6+1+1
//                     grid_done
//   cfg_*_i     in    grid_rows (idx 0), grid_cols (idx 1)    11
//
// one height word is taken per cycle; the front classifies it in that cycle
// against a window of neighbors fed from a 64-entry line memory read two
// columns ahead. the back sends one result word per cycle while out_o is
// ready, so a last-row word with up to three peaks gives up to three result
// words. a four-entry event queue lets input continue while results stall;
// input stalls only when it is full. no clearing pass after reset.
`default_nettype none

module grid_local_peak_finder_top import glpf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  glpf_in_if.sink             in_i,
  glpf_out_if.source          out_o
);

  logic      push, q_full, q_valid, pop;
  glpf_evt_t evt, head;

  glpf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .evt_o      (evt)
  );

  glpf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .evt_i   (evt),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head)
  );

  glpf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .head_i    (head),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

FILE: rtl/glpf_front.sv
// front end: position, line memory, neighbor window and peak classification
`default_nettype none

module glpf_front import glpf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  glpf_in_if.sink             in_i,
  input  logic                q_full_i,
  output logic                push_o,
  output glpf_evt_t           evt_o
);

  logic [RowW-1:0] row_q, row_d, last_row_q, last_row_d;
  logic [ColW-1:0] col_q, col_d, last_col_q, last_col_d;

  // each entry holds {two rows up, one row up} of its column
  logic [2*HeightW-1:0] line_mem_q [MaxCols];
  logic [2*HeightW-1:0] rd_q;
  logic [2*HeightW-1:0] win_q;
  logic [2*HeightW-1:0] wr_data;
  logic signed [HeightW-1:0] ul_q, left_q, left2_q;

  logic signed [HeightW-1:0] x, up1, up2, right;
  logic                      accept, first_col, end_col, end_row;
  logic [HitW-1:0]           hits;
  logic [ColW:0]             ahead2;
  logic [ColW-1:0]           rd_addr;
  logic [CfgRowsW-1:0]       rows_w;
  logic [CfgColsW-1:0]       cols_w;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;

  assign x     = in_i.height;
  assign up1   = $signed(win_q[HeightW-1:0]);
  assign up2   = $signed(win_q[2*HeightW-1:HeightW]);
  assign right = $signed(rd_q[HeightW-1:0]);

  assign first_col = (col_q == '0);
  assign end_col   = (col_q == last_col_q);
  assign end_row   = (row_q == last_row_q);

  always_comb begin
    hits = '0;
    hits[HitAbove] = (row_q != '0) && (up1 >= x)
                     && ((row_q == RowW'(1)) || (up1 >= up2))
                     && (first_col || (up1 >= ul_q))
                     && (end_col || (up1 >= right));
    hits[HitLeft]  = end_row && !first_col && (left_q >= x) && (left_q >= ul_q)
                     && ((col_q == ColW'(1)) || (left_q >= left2_q));
    hits[HitSelf]  = end_row && end_col && (x >= up1) && (x >= left_q);
  end

  assign push_o          = accept && (hits != '0);
  assign evt_o.hits      = hits;
  assign evt_o.row       = row_q;
  assign evt_o.col       = col_q;
  assign evt_o.last_cell = end_row && end_col;

  // fetch two columns ahead, wrapping into the next row
  assign ahead2  = {1'b0, col_q} + (ColW+1)'(2);
  assign rd_addr = (ahead2 > {1'b0, last_col_q})
                   ? ColW'(ahead2 - {1'b0, last_col_q} - (ColW+1)'(1))
                   : ColW'(ahead2);
  assign wr_data = {win_q[HeightW-1:0], x};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_mem_q[col_q] <= wr_data;
      // narrow grids read the entry being written
      if (rd_addr == col_q) begin
        rd_q <= wr_data;
      end else begin
        rd_q <= line_mem_q[rd_addr];
      end
      win_q   <= rd_q;
      ul_q    <= up1;
      left2_q <= left_q;
      left_q  <= x;
    end
  end

  assign rows_w = cfg_data_i[CfgRowsW-1:0];
  assign cols_w = cfg_data_i[CfgColsW-1:0];

  always_comb begin
    last_row_d = last_row_q;
    last_col_d = last_col_q;
    row_d      = row_q;
    col_d      = col_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgGridRows: begin
          if (rows_w < CfgRowsW'(2)) begin
            last_row_d = RowW'(1);
          end else if (32'(rows_w) > MaxRows) begin
            last_row_d = RowW'(MaxRows - 1);
          end else begin
            last_row_d = RowW'(rows_w - CfgRowsW'(1));
          end
          row_d = '0;
          col_d = '0;
        end
        CfgGridCols: begin
          if (cols_w < CfgColsW'(2)) begin
            last_col_d = ColW'(1);
          end else if (32'(cols_w) > MaxCols) begin
            last_col_d = ColW'(MaxCols - 1);
          end else begin
            last_col_d = ColW'(cols_w - CfgColsW'(1));
          end
          row_d = '0;
          col_d = '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (end_col) begin
        col_d = '0;
        row_d = end_row ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      last_row_q <= ResetLastRow;
      last_col_q <= ResetLastCol;
    end else begin
      row_q      <= row_d;
      col_q      <= col_d;
      last_row_q <= last_row_d;
      last_col_q <= last_col_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/glpf_queue.sv
// short event queue between front and back
`default_nettype none

module glpf_queue import glpf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  glpf_evt_t evt_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output glpf_evt_t head_o
);

  glpf_evt_t        slot_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == (QPtrW+1)'(QDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= evt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (QPtrW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (QPtrW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/glpf_back.sv
// back end: expands each event into result words in raster order
`default_nettype none

module glpf_back import glpf_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  glpf_evt_t     head_i,
  output logic          pop_o,
  glpf_out_if.source    out_o
);

  logic [HitW-1:0] cur_mask_q;
  logic [RowW-1:0] cur_row_q;
  logic [ColW-1:0] cur_col_q;
  logic            cur_last_q;

  logic            out_valid_q;
  logic [RowW-1:0] out_row_q, out_row_d;
  logic [ColW-1:0] out_col_q, out_col_d;
  logic            out_lor_q, out_done_q;

  logic            advance, use_cur, have;
  logic [HitW-1:0] src_mask, rem;
  logic [RowW-1:0] src_row;
  logic [ColW-1:0] src_col;
  logic            src_last;

  assign advance  = !out_valid_q || out_o.ready;
  assign use_cur  = (cur_mask_q != '0);
  assign have     = use_cur || q_valid_i;
  assign pop_o    = advance && !use_cur && q_valid_i;

  assign src_mask = use_cur ? cur_mask_q : head_i.hits;
  assign src_row  = use_cur ? cur_row_q : head_i.row;
  assign src_col  = use_cur ? cur_col_q : head_i.col;
  assign src_last = use_cur ? cur_last_q : head_i.last_cell;

  // lowest pending hit goes out first
  always_comb begin
    rem       = src_mask;
    out_row_d = src_row;
    out_col_d = src_col;
    if (src_mask[HitAbove]) begin
      rem[HitAbove] = 1'b0;
      out_row_d     = src_row - RowW'(1);
    end else if (src_mask[HitLeft]) begin
      rem[HitLeft] = 1'b0;
      out_col_d    = src_col - ColW'(1);
    end else begin
      rem[HitSelf] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_row_q  <= head_i.row;
      cur_col_q  <= head_i.col;
      cur_last_q <= head_i.last_cell;
    end
    if (advance && have) begin
      out_row_q  <= out_row_d;
      out_col_q  <= out_col_d;
      out_lor_q  <= (rem == '0);
      out_done_q <= (rem == '0) && src_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_mask_q  <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= have;
      if (have) begin
        cur_mask_q <= rem;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.peak_row    = out_row_q;
  assign out_o.peak_col    = out_col_q;
  assign out_o.last_of_run = out_lor_q;
  assign out_o.grid_done   = out_done_q;

endmodule

`default_nettype wire
